FILE: rtl/core/nlmm_pkg.sv
// ----------------------------------------------------------------------------
// nlmm_pkg - shared definitions for the noise level mean/peak meter
// Widths, limits and the sequencer state type used by the core and its
// stream interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package nlmm_pkg;

   // sample and statistics sizing
   localparam int ADC_BITS   = 10;
   localparam int BLOCK_LOG2 = 5;
   localparam int COUNT_BITS = 16;

   // derived widths
   localparam int ACC_W = ADC_BITS + BLOCK_LOG2;   // sum of one group of samples
   localparam int SUM_W = ADC_BITS + COUNT_BITS;   // sum of counted block averages
   localparam int NUM_W = SUM_W + 1;               // 2*sum + count
   localparam int DEN_W = COUNT_BITS + 1;          // 2*count
   localparam int CNT_W = $clog2(NUM_W);           // divider step counter

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [BLOCK_LOG2-1:0] POS_LAST  = '1;

   // command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FINISH,
      ST_DIV,
      ST_DONE
   } nlmm_state_type;

endpackage

`default_nettype wire

FILE: rtl/core/nlmm_req_if.sv
// ----------------------------------------------------------------------------
// nlmm_req_if - request stream of the noise level meter
// Carries one command beat: an ADC sample or a report request.
// ----------------------------------------------------------------------------
`default_nettype none

interface nlmm_req_if;
   import nlmm_pkg::*;

   logic                valid;
   logic                ready;
   logic                cmd;
   logic [ADC_BITS-1:0] sample;

   modport source (output valid, output cmd, output sample, input ready);
   modport sink   (input valid, input cmd, input sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/nlmm_rsp_if.sv
// ----------------------------------------------------------------------------
// nlmm_rsp_if - response stream of the noise level meter
// Carries one report beat: rounded mean, peak and block count.
// ----------------------------------------------------------------------------
`default_nettype none

interface nlmm_rsp_if;
   import nlmm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ADC_BITS-1:0]   mean_noise;
   logic [ADC_BITS-1:0]   peak_noise;
   logic [COUNT_BITS-1:0] block_count;

   modport source (output valid, output mean_noise, output peak_noise,
                   output block_count, input ready);
   modport sink   (input valid, input mean_noise, input peak_noise,
                   input block_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/noise_level_mean_max_core.sv
// ----------------------------------------------------------------------------
// noise_level_mean_max_core - block-average noise meter with mean and peak
//
// Usage:
//   req_bus takes command beats. cmd = sample adds an ADC value to the
//   current group of 32; when a group completes its average (sum >> 5)
//   updates the peak, the running sum and the saturating block count.
//   cmd = report produces one beat on rsp_bus with the mean of the counted
//   block averages rounded half up (0 with no blocks), the peak and the
//   count, then clears those statistics. A partial group is kept.
//   Timing: a sample that closes a group also passes through ST_FINISH,
//   which folds the average into peak/sum/count. A report loads the
//   divider, runs the bit-serial restoring divider (one quotient bit per
//   cycle through a single shared subtractor) and then moves the result
//   into the output register once it is free.
//   req_bus.ready is low while the sequencer is busy. The response sits in
//   an output register; a stalled receiver only blocks the next report in
//   ST_DONE, which also holds off samples; until then samples keep flowing.
//   Reset (synchronous, active high) clears the group, the statistics and
//   drops any pending response.
// ----------------------------------------------------------------------------
`default_nettype none

module noise_level_mean_max_core (
   input  wire logic   clock,
   input  wire logic   reset,
   nlmm_req_if.sink    req_bus,
   nlmm_rsp_if.source  rsp_bus
);
   import nlmm_pkg::*;

   nlmm_state_type        state_ff, state_in;
   logic [ACC_W-1:0]      block_acc_ff, block_acc_in;
   logic [BLOCK_LOG2-1:0] block_pos_ff, block_pos_in;
   logic [SUM_W-1:0]      level_sum_ff, level_sum_in;
   logic [COUNT_BITS-1:0] level_count_ff, level_count_in;
   logic [ADC_BITS-1:0]   level_peak_ff, level_peak_in;

   // divider and report holding registers
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      step_ff, step_in;
   logic [ADC_BITS-1:0]   peak_hold_ff, peak_hold_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADC_BITS-1:0]   mean_out_ff, mean_out_in;
   logic [ADC_BITS-1:0]   peak_out_ff, peak_out_in;
   logic [COUNT_BITS-1:0] count_out_ff, count_out_in;

   logic                  req_fire;
   logic [ADC_BITS-1:0]   block_avg;
   logic [DEN_W:0]        rem_shift;
   logic [DEN_W:0]        rem_diff;
   logic                  rem_ge;
   logic [COUNT_BITS-1:0] rep_count;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.mean_noise  = mean_out_ff;
   assign rsp_bus.peak_noise  = peak_out_ff;
   assign rsp_bus.block_count = count_out_ff;

   // average of a finished group
   assign block_avg = block_acc_ff[BLOCK_LOG2 +: ADC_BITS];

   // shared subtract/compare unit of the restoring divider
   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign rem_ge    = (rem_shift >= {1'b0, den_ff});

   // count captured at the report, kept in the divisor
   assign rep_count = den_ff[COUNT_BITS:1];

   // state register and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         block_acc_ff   <= '0;
         block_pos_ff   <= '0;
         level_sum_ff   <= '0;
         level_count_ff <= '0;
         level_peak_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         block_acc_ff   <= block_acc_in;
         block_pos_ff   <= block_pos_in;
         level_sum_ff   <= level_sum_in;
         level_count_ff <= level_count_in;
         level_peak_ff  <= level_peak_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      num_ff       <= num_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      peak_hold_ff <= peak_hold_in;
      mean_out_ff  <= mean_out_in;
      peak_out_ff  <= peak_out_in;
      count_out_ff <= count_out_in;
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in       = state_ff;
      block_acc_in   = block_acc_ff;
      block_pos_in   = block_pos_ff;
      level_sum_in   = level_sum_ff;
      level_count_in = level_count_ff;
      level_peak_in  = level_peak_ff;
      num_in         = num_ff;
      den_in         = den_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      peak_hold_in   = peak_hold_ff;
      mean_out_in    = mean_out_ff;
      peak_out_in    = peak_out_ff;
      count_out_in   = count_out_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.cmd == CMD_SAMPLE) begin
                  // accumulate one sample into the current group
                  block_acc_in = block_acc_ff + ACC_W'(req_bus.sample);
                  block_pos_in = block_pos_ff + 1'b1;
                  if (block_pos_ff == POS_LAST) begin
                     state_in = ST_FINISH;
                  end
               end else begin
                  // snapshot statistics into the divider, then clear them
                  num_in         = {level_sum_ff, 1'b0} + NUM_W'(level_count_ff);
                  den_in         = {level_count_ff, 1'b0};
                  rem_in         = '0;
                  step_in        = CNT_W'(NUM_W - 1);
                  peak_hold_in   = level_peak_ff;
                  level_sum_in   = '0;
                  level_count_in = '0;
                  level_peak_in  = '0;
                  state_in       = ST_DIV;
               end
            end
         end

         ST_FINISH: begin
            // fold the group average into peak, and into sum and count unless saturated
            if (block_avg > level_peak_ff) begin
               level_peak_in = block_avg;
            end
            if (level_count_ff != COUNT_MAX) begin
               level_sum_in   = level_sum_ff + SUM_W'(block_avg);
               level_count_in = level_count_ff + 1'b1;
            end
            block_acc_in = '0;
            state_in     = ST_IDLE;
         end

         ST_DIV: begin
            // one quotient bit per cycle
            rem_in = rem_ge ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], rem_ge};
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end

         ST_DONE: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               mean_out_in  = (rep_count == '0) ? '0 : num_ff[ADC_BITS-1:0];
               peak_out_in  = peak_hold_ff;
               count_out_in = rep_count;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   // a report clears the statistics on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bus.cmd == CMD_REPORT) |=>
         (level_count_ff == '0 && level_sum_ff == '0 && level_peak_ff == '0))
      else $error("statistics not cleared after report");

   // a group only closes right after the position wrapped
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (block_pos_ff == '0))
      else $error("group closed at nonzero position");

   // the rounded mean never exceeds the peak
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (mean_out_ff <= peak_out_ff))
      else $error("mean above peak");

   // divider remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && den_ff != '0) |-> (rem_ff < den_ff))
      else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for noise_level_mean_max_core
// Feeds sample and report beats with random gaps, tracks the group sum,
// running sum, peak and block count alongside the core, and compares
// every report beat field by field against the value worked out when its
// request beat was taken.
// ----------------------------------------------------------------------------
module tb;
   import nlmm_pkg::*;

   localparam int GROUP_LEN = 1 << BLOCK_LOG2;

   typedef struct {
      logic                cmd;
      logic [ADC_BITS-1:0] sample;
      bit                  drain;   // hold this beat until no report is owed
   } meter_beat_type;

   typedef struct {
      logic [ADC_BITS-1:0]   mean_noise;
      logic [ADC_BITS-1:0]   peak_noise;
      logic [COUNT_BITS-1:0] block_count;
   } noise_report_type;

   typedef enum int {
      GRP_RANDOM,
      GRP_FULL,
      GRP_SILENT,
      GRP_STEADY
   } group_shape_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nlmm_req_if req_bus ();
   nlmm_rsp_if rsp_bus ();

   noise_level_mean_max_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #1 clock = ~clock;

   meter_beat_type   beat_queue[$];
   noise_report_type report_queue[$];
   meter_beat_type   next_beat;
   noise_report_type owed_report;

   int sent_beats     = 0;
   int got_reports    = 0;
   int error_count    = 0;

   // shadow copy of the meter state
   logic [ACC_W-1:0]      grp_acc   = '0;
   logic [BLOCK_LOG2-1:0] grp_pos   = '0;
   logic [SUM_W-1:0]      lvl_sum   = '0;
   logic [COUNT_BITS-1:0] lvl_count = '0;
   logic [ADC_BITS-1:0]   lvl_peak  = '0;

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // advance the shadow state by one taken beat; a report owes one result
   function automatic void fold_beat(input logic cmd, input logic [ADC_BITS-1:0] sample);
      logic [ADC_BITS-1:0] avg;
      longint unsigned     num;
      longint unsigned     den;
      noise_report_type    rep;
      if (cmd == CMD_SAMPLE) begin
         grp_acc = grp_acc + ACC_W'(sample);
         grp_pos = grp_pos + 1'b1;
         // group closed: average feeds peak, and sum/count unless saturated
         if (grp_pos == '0) begin
            avg = ADC_BITS'(grp_acc >> BLOCK_LOG2);
            if (avg > lvl_peak) lvl_peak = avg;
            if (lvl_count != COUNT_MAX) begin
               lvl_sum   = lvl_sum + SUM_W'(avg);
               lvl_count = lvl_count + 1'b1;
            end
            grp_acc = '0;
         end
      end else begin
         // mean rounded half up, zero with no blocks
         num = 2 * longint'(lvl_sum) + longint'(lvl_count);
         den = 2 * longint'(lvl_count);
         rep.mean_noise  = (lvl_count == '0) ? '0 : ADC_BITS'(num / den);
         rep.peak_noise  = lvl_peak;
         rep.block_count = lvl_count;
         report_queue.push_back(rep);
         lvl_sum   = '0;
         lvl_count = '0;
         lvl_peak  = '0;
      end
   endfunction

   task automatic queue_sample(input int value);
      meter_beat_type b;
      b.cmd    = CMD_SAMPLE;
      b.sample = ADC_BITS'(value);
      b.drain  = 1'b0;
      beat_queue.push_back(b);
   endtask

   task automatic queue_report(input bit drain);
      meter_beat_type b;
      b.cmd    = CMD_REPORT;
      b.sample = ADC_BITS'($urandom);   // ignored by a report
      b.drain  = drain;
      beat_queue.push_back(b);
   endtask

   // one full group of samples shaped by the chosen level pattern
   task automatic queue_group(input group_shape_type shape);
      int base;
      int spread;
      int v;
      base   = $urandom_range(1023);
      spread = $urandom_range(64);
      for (int k = 0; k < GROUP_LEN; k++) begin
         case (shape)
            GRP_RANDOM: v = $urandom_range(1023);
            GRP_FULL:   v = 1023;
            GRP_SILENT: v = 0;
            default: begin
               v = base + $urandom_range(2 * spread) - spread;
               if (v < 0) v = 0;
               if (v > 1023) v = 1023;
            end
         endcase
         queue_sample(v);
         // occasional stray report within or right after a group
         if ($urandom_range(199) == 0) queue_report(1'b0);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            fold_beat(req_bus.cmd, req_bus.sample);
            sent_beats++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (beat_queue.size() != 0 &&
                !(beat_queue[0].drain && report_queue.size() != 0) &&
                ((sent_beats >= 250 && sent_beats < 420) || $urandom_range(99) >= 38)) begin
               next_beat = beat_queue.pop_front();
               req_bus.valid  <= 1'b1;
               req_bus.cmd    <= next_beat.cmd;
               req_bus.sample <= next_beat.sample;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // report monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_reports++;
            if (report_queue.size() == 0) begin
               flag_mismatch($sformatf("report beat %0d arrived with none owed", got_reports));
            end else begin
               owed_report = report_queue.pop_front();
               if (rsp_bus.mean_noise !== owed_report.mean_noise)
                  flag_mismatch($sformatf("report %0d mean_noise got %0d want %0d", got_reports,
                                          rsp_bus.mean_noise, owed_report.mean_noise));
               if (rsp_bus.peak_noise !== owed_report.peak_noise)
                  flag_mismatch($sformatf("report %0d peak_noise got %0d want %0d", got_reports,
                                          rsp_bus.peak_noise, owed_report.peak_noise));
               if (rsp_bus.block_count !== owed_report.block_count)
                  flag_mismatch($sformatf("report %0d block_count got %0d want %0d", got_reports,
                                          rsp_bus.block_count, owed_report.block_count));
            end
         end
         rsp_bus.ready <= (got_reports >= 12 && got_reports < 24) || $urandom_range(99) >= 38;
      end
   end

   // stimulus and end of run
   initial begin
      int nblocks;
      int nstray;
      req_bus.valid  = 1'b0;
      req_bus.cmd    = CMD_SAMPLE;
      req_bus.sample = '0;
      rsp_bus.ready  = 1'b0;

      // report with nothing collected
      queue_report(1'b0);
      // partial group survives a report
      for (int k = 0; k < 3; k++) queue_sample(1023);
      queue_report(1'b0);
      // finish that group at full scale, then report after everything settles
      for (int k = 3; k < GROUP_LEN; k++) queue_sample(1023);
      queue_report(1'b1);
      // back-to-back report sees cleared statistics
      queue_report(1'b0);

      // well-formed runs of groups with random content, plus stray beats
      while (beat_queue.size() < 650) begin
         if ($urandom_range(9) == 0) begin
            nstray = $urandom_range(1, 10);
            repeat (nstray) queue_sample($urandom_range(1023));
         end
         nblocks = $urandom_range(0, 2);
         repeat (nblocks) begin
            if ($urandom_range(3) == 0)
               queue_group(group_shape_type'($urandom_range(2)));
            else
               queue_group(GRP_STEADY);
         end
         queue_report($urandom_range(7) == 0);
         if ($urandom_range(5) == 0) queue_report(1'b0);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (beat_queue.size() != 0 || req_bus.valid) @(posedge clock);
      while (report_queue.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      if (error_count == 0 && report_queue.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/nlmm_pkg.sv
rtl/core/nlmm_req_if.sv
rtl/core/nlmm_rsp_if.sv
rtl/core/noise_level_mean_max_core.sv
tb/tb.sv
